>>> src/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet for the base64 stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            final_job;
    } job_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        begin
            if (v < 6'd26)
            begin
                c = 8'h41 + {2'b00, v};
            end
            else if (v < 6'd52)
            begin
                c = 8'h61 + {2'b00, v} - 8'd26;
            end
            else if (v < 6'd62)
            begin
                c = 8'h30 + {2'b00, v} - 8'd52;
            end
            else if (v == 6'd62)
            begin
                c = 8'h2B;
            end
            else
            begin
                c = 8'h2F;
            end
            return c;
        end
    endfunction

endpackage

>>> src/base64_stream_encoder_core.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// Standard base64 encoder: bytes in, alphabet characters and padding out.
//
//   Channel | Handshake    | Payload
//   --------+--------------+-------------------------
//   input   | push / full  | data_byte, final_byte
//   output  | pop / empty  | text_char, end_of_text
//
// A byte yields one to four characters; the output side gives one character
// per cycle while each character is popped. The front takes a new byte in
// any cycle the two-entry queue is not full. Each character of the group at
// the head of the queue is loaded into the output register once it is empty
// or being popped. Reset clears the phase, the queue and the output.
// ----------------------------------------------------------------------------
module base64_stream_encoder_core
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] text_char,
    output logic       end_of_text
);

    logic accept;
    job_t front_job;
    job_t head_job;
    logic queue_empty;
    logic head_done;

    assign accept = push && !full;

    b64e_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .job        (front_job)
    );

    b64e_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_job (front_job),
        .rd_en  (head_done),
        .rd_job (head_job),
        .full   (full),
        .empty  (queue_empty)
    );

    b64e_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (!queue_empty),
        .head_job    (head_job),
        .head_done   (head_done),
        .pop         (pop),
        .empty       (empty),
        .text_char   (text_char),
        .end_of_text (end_of_text)
    );

endmodule

>>> src/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Takes one byte per request, tracks the group phase and leftover bits,
// and forms the complete set of characters that the byte produces.
// ----------------------------------------------------------------------------
module b64e_front
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output job_t       job
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] left_reg;
    logic [3:0] left_next;

    always_comb
    begin
        job.chars     = {PAD_CHAR, PAD_CHAR, PAD_CHAR, PAD_CHAR};
        job.last_idx  = 2'd0;
        job.final_job = final_byte;
        phase_next    = PHASE_FIRST;
        left_next     = 4'd0;
        unique case (phase_reg)
            PHASE_SECOND:
            begin
                job.chars[0] = sextet_char({left_reg[1:0], data_byte[7:4]});
                if (final_byte)
                begin
                    job.chars[1] = sextet_char({data_byte[3:0], 2'b00});
                    job.last_idx = 2'd2;
                end
                else
                begin
                    phase_next = PHASE_THIRD;
                    left_next  = data_byte[3:0];
                end
            end
            PHASE_THIRD:
            begin
                job.chars[0] = sextet_char({left_reg, data_byte[7:6]});
                job.chars[1] = sextet_char(data_byte[5:0]);
                job.last_idx = 2'd1;
            end
            default:
            begin
                job.chars[0] = sextet_char(data_byte[7:2]);
                if (final_byte)
                begin
                    job.chars[1] = sextet_char({data_byte[1:0], 4'b0000});
                    job.last_idx = 2'd3;
                end
                else
                begin
                    phase_next = PHASE_SECOND;
                    left_next  = {2'b00, data_byte[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_FIRST;
            left_reg  <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

>>> src/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Short queue of character groups between the front and the back.
// ----------------------------------------------------------------------------
module b64e_queue
    import b64e_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    input  logic rd_en,
    output job_t rd_job,
    output logic full,
    output logic empty
);

    job_t                   slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full   = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = slots_reg[rd_ptr_reg];

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> src/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Walks the characters of the oldest group into the output register, one per
// cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module b64e_back
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  job_t       head_job,
    output logic       head_done,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] text_char,
    output logic       end_of_text
);

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] char_reg;
    logic       end_reg;
    logic       load;
    logic       at_last;

    assign empty       = !out_valid_reg;
    assign text_char   = char_reg;
    assign end_of_text = end_reg;
    assign load        = head_valid && (!out_valid_reg || pop);
    assign at_last     = (idx_reg == head_job.last_idx);
    assign head_done   = load && at_last;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= head_job.chars[idx_reg];
            end_reg  <= head_job.final_job && at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= at_last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
